// ----- design/mbrs_pkg.sv -----
package mbrs_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int LEN_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0]  FC_READ_INPUTS  = 8'h02;
    localparam logic [7:0]  FC_WRITE_COIL   = 8'h05;
    localparam logic [7:0]  COIL_ON         = 8'hFF;
    localparam logic [7:0]  READ_BYTE_COUNT = 8'h01;
    localparam int          MIN_FRAME_BYTES = 4;
    localparam int          MIN_ECHO_BYTES  = 5;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam logic [1:0] ST_ANSWERED      = 2'd0;
    localparam logic [1:0] ST_CRC_ERR       = 2'd1;
    localparam logic [1:0] ST_OTHER_STATION = 2'd2;
    localparam logic [1:0] ST_UNHANDLED     = 2'd3;

    localparam logic [1:0] CFG_SLAVE_ADDR  = 2'd0;
    localparam logic [1:0] CFG_COIL_ADDR   = 2'd1;
    localparam logic [1:0] CFG_INPUTS_ADDR = 2'd2;

    localparam logic [LEN_W-1:0] RSP_CRC_LO_IDX = LEN_W'(4);
    localparam logic [LEN_W-1:0] RSP_LAST_IDX   = LEN_W'(5);
    localparam logic [LEN_W-1:0] RSP_IDX_SLAVE  = LEN_W'(0);
    localparam logic [LEN_W-1:0] RSP_IDX_FUNC   = LEN_W'(1);
    localparam logic [LEN_W-1:0] RSP_IDX_COUNT  = LEN_W'(2);
    localparam logic [LEN_W-1:0] RSP_IDX_DATA   = LEN_W'(3);

    typedef enum logic [1:0] {
        DK_STATUS,
        DK_READ,
        DK_ECHO
    } t_desc_kind;

    typedef struct packed {
        t_desc_kind       kind;
        logic [1:0]       status;
        logic             relay;
        logic             bank;
        logic [LEN_W-1:0] last_idx;
        logic [7:0]       slave;
        logic [7:0]       in_byte;
    } t_desc;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ECHO_RD,
        S_ECHO_WR
    } t_bk_state;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- design/mbrs_queue.sv -----
module mbrs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbrs_pkg::t_desc i_push_desc,
    input  logic           i_pop,
    output mbrs_pkg::t_desc o_head,
    output logic           o_empty,
    output logic           o_full
);
    import mbrs_pkg::*;

    t_desc      r_entry [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wp] <= i_push_desc;
        end
    end

    assign o_head  = r_entry[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// ----- design/mbrs_front.sv -----
module mbrs_front #(
    parameter int FRAME_BYTES = 32,
    parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_frame_end,
    input  logic [2:0]       i_button_levels,
    input  logic [7:0]       i_slave_address,
    input  logic [15:0]      i_relay_coil_address,
    input  logic [15:0]      i_inputs_address,
    input  logic             i_q_full,
    output logic             o_push,
    output mbrs_pkg::t_desc  o_push_desc,
    output logic             o_wr_en,
    output logic             o_wr_bank,
    output logic [IDX_W-1:0] o_wr_idx,
    output logic [7:0]       o_wr_data
);
    import mbrs_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_relay;
    logic             r_bank;
    logic [15:0]      r_crc;
    logic [7:0]       r_d0;
    logic [7:0]       r_d1;
    logic [7:0]       r_b [5];

    logic             accept;
    logic             fits;
    logic [CNT_W-1:0] n_len;
    logic [6:0]       len_ext;
    logic [15:0]      crc_fin;
    logic             crc_bad;
    logic [7:0]       fb [5];
    logic [15:0]      adr;
    t_desc            desc;

    assign accept  = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign fits    = (r_count < CNT_W'(FRAME_BYTES));
    assign n_len   = r_count + {{(CNT_W-1){1'b0}}, fits};
    assign len_ext = 7'(n_len);
    assign crc_fin = (r_count >= CNT_W'(2)) ? crc_step(r_crc, r_d0) : r_crc;
    assign crc_bad = (crc_fin[7:0] != r_d1) || (crc_fin[15:8] != i_rx_byte);

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            fb[k] = (r_count == CNT_W'(k)) ? i_rx_byte : r_b[k];
        end
    end

    assign adr = {fb[2], fb[3]};

    always_comb begin
        desc          = '0;
        desc.kind     = DK_STATUS;
        desc.status   = ST_UNHANDLED;
        desc.relay    = r_relay;
        desc.bank     = r_bank;
        desc.last_idx = LEN_W'(n_len - CNT_W'(1));
        desc.slave    = fb[0];
        desc.in_byte  = {4'b0000, r_relay, i_button_levels};
        if (r_ovf || !fits || (n_len < CNT_W'(MIN_FRAME_BYTES)) || crc_bad) begin
            desc.status = ST_CRC_ERR;
        end else if (fb[0] != i_slave_address) begin
            desc.status = ST_OTHER_STATION;
        end else if ((fb[1] == FC_READ_INPUTS) && (adr == i_inputs_address)) begin
            desc.kind   = DK_READ;
            desc.status = ST_ANSWERED;
        end else if ((fb[1] == FC_WRITE_COIL) && (adr == i_relay_coil_address) &&
                     (len_ext >= 7'(MIN_ECHO_BYTES)) && (len_ext <= 7'(MAX_RESULTS))) begin
            desc.kind   = DK_ECHO;
            desc.status = ST_ANSWERED;
            desc.relay  = (fb[4] == COIL_ON);
        end
    end

    assign o_push      = accept && i_frame_end;
    assign o_push_desc = desc;
    assign o_wr_en     = accept && fits;
    assign o_wr_bank   = r_bank;
    assign o_wr_idx    = r_count[IDX_W-1:0];
    assign o_wr_data   = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_relay <= 1'b0;
            r_bank  <= 1'b0;
            r_crc   <= CRC_INIT;
        end else if (accept) begin
            if (i_frame_end) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_crc   <= CRC_INIT;
                r_bank  <= ~r_bank;
                r_relay <= desc.relay;
            end else if (fits) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count >= CNT_W'(2)) begin
                    r_crc <= crc_step(r_crc, r_d0);
                end
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && fits) begin
            r_d0 <= r_d1;
            r_d1 <= i_rx_byte;
            for (int k = 0; k < 5; k++) begin
                if (r_count == CNT_W'(k)) begin
                    r_b[k] <= i_rx_byte;
                end
            end
        end
    end

endmodule

// ----- design/mbrs_back.sv -----
module mbrs_back #(
    parameter int FRAME_BYTES = 32,
    parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbrs_pkg::t_desc  i_head,
    input  logic             i_q_empty,
    output logic             o_pop,
    input  logic             i_wr_en,
    input  logic             i_wr_bank,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [7:0]       i_wr_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte,
    output logic             o_tx_last,
    output logic [1:0]       o_frame_status,
    output logic             o_relay_level
);
    import mbrs_pkg::*;

    logic [7:0] r_frame_mem [2][FRAME_BYTES];
    logic [7:0] r_rd_data;

    t_bk_state        r_state;
    t_bk_state        n_state;
    logic [LEN_W-1:0] r_idx;
    logic [LEN_W-1:0] n_idx;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;

    logic       r_out_valid;
    logic       r_tx_valid;
    logic [7:0] r_tx_byte;
    logic       r_tx_last;
    logic [1:0] r_status;
    logic       r_relay;

    logic       can_load;
    logic       load;
    logic       rd_en;
    logic       ld_txv;
    logic [7:0] ld_byte;
    logic       ld_last;
    logic [7:0] rsp_byte;

    assign can_load = !r_out_valid || !i_stall;

    always_comb begin
        unique case (r_idx)
            RSP_IDX_SLAVE:  rsp_byte = i_head.slave;
            RSP_IDX_FUNC:   rsp_byte = FC_READ_INPUTS;
            RSP_IDX_COUNT:  rsp_byte = READ_BYTE_COUNT;
            RSP_IDX_DATA:   rsp_byte = i_head.in_byte;
            RSP_CRC_LO_IDX: rsp_byte = r_crc[7:0];
            default:        rsp_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_crc   = r_crc;
        o_pop   = 1'b0;
        load    = 1'b0;
        rd_en   = 1'b0;
        ld_txv  = 1'b0;
        ld_byte = 8'h00;
        ld_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_head.kind)
                        DK_READ: begin
                            n_state = S_READ;
                            n_idx   = '0;
                            n_crc   = CRC_INIT;
                        end
                        DK_ECHO: begin
                            n_state = S_ECHO_RD;
                            n_idx   = '0;
                        end
                        default: begin
                            if (can_load) begin
                                load    = 1'b1;
                                ld_last = 1'b1;
                                o_pop   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (can_load) begin
                    load    = 1'b1;
                    ld_txv  = 1'b1;
                    ld_byte = rsp_byte;
                    ld_last = (r_idx == RSP_LAST_IDX);
                    if (r_idx < RSP_CRC_LO_IDX) begin
                        n_crc = crc_step(r_crc, rsp_byte);
                    end
                    if (r_idx == RSP_LAST_IDX) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + LEN_W'(1);
                    end
                end
            end
            S_ECHO_RD: begin
                rd_en   = 1'b1;
                n_state = S_ECHO_WR;
            end
            S_ECHO_WR: begin
                if (can_load) begin
                    load    = 1'b1;
                    ld_txv  = 1'b1;
                    ld_byte = r_rd_data;
                    ld_last = (r_idx == i_head.last_idx);
                    if (r_idx == i_head.last_idx) begin
                        o_pop   = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + LEN_W'(1);
                        n_state = S_ECHO_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_crc <= n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_frame_mem[i_wr_bank][i_wr_idx] <= i_wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_frame_mem[i_head.bank][IDX_W'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tx_valid <= ld_txv;
            r_tx_byte  <= ld_byte;
            r_tx_last  <= ld_last;
            r_status   <= i_head.status;
            r_relay    <= i_head.relay;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_tx_last      = r_tx_last;
    assign o_frame_status = r_status;
    assign o_relay_level  = r_relay;

endmodule

// ----- design/modbus_rtu_slave_responder.sv -----
// Modbus RTU slave responder. Received bytes are taken one per clock, each with a frame-end
// flag; the frame is written into one bank of a two-bank byte store while its CRC-16 runs
// alongside. At frame end the frame is classified and a job is queued for the response side,
// so the next frame can be received while the previous one is still answered. Input stalls only
// while two finished frames await their response. Each frame yields either one status-only
// result, a six-byte read-inputs reply at one byte per clock while the output does not stall
// (CRC computed as the bytes go out), or an echo of the write-coil frame, each byte first
// registered out of the frame store, then sent. The store needs no clearing after reset.
module modbus_rtu_slave_responder #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    input  logic [2:0]  i_button_levels,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [1:0]  o_frame_status,
    output logic        o_relay_level,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import mbrs_pkg::*;

    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [7:0]  r_slave_address;
    logic [15:0] r_relay_coil_address;
    logic [15:0] r_inputs_address;

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    t_desc            push_desc;
    t_desc            head;
    logic             wr_en;
    logic             wr_bank;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address      <= 8'h01;
            r_relay_coil_address <= 16'h0000;
            r_inputs_address     <= 16'h0000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SLAVE_ADDR:  r_slave_address      <= i_cfg_data[7:0];
                CFG_COIL_ADDR:   r_relay_coil_address <= i_cfg_data;
                CFG_INPUTS_ADDR: r_inputs_address     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mbrs_front #(
        .FRAME_BYTES(FRAME_BYTES),
        .IDX_W      (IDX_W)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .i_frame_end         (i_frame_end),
        .i_button_levels     (i_button_levels),
        .i_slave_address     (r_slave_address),
        .i_relay_coil_address(r_relay_coil_address),
        .i_inputs_address    (r_inputs_address),
        .i_q_full            (q_full),
        .o_push              (push),
        .o_push_desc         (push_desc),
        .o_wr_en             (wr_en),
        .o_wr_bank           (wr_bank),
        .o_wr_idx            (wr_idx),
        .o_wr_data           (wr_data)
    );

    mbrs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_desc(push_desc),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    mbrs_back #(
        .FRAME_BYTES(FRAME_BYTES),
        .IDX_W      (IDX_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .i_wr_en       (wr_en),
        .i_wr_bank     (wr_bank),
        .i_wr_idx      (wr_idx),
        .i_wr_data     (wr_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tx_valid    (o_tx_valid),
        .o_tx_byte     (o_tx_byte),
        .o_tx_last     (o_tx_last),
        .o_frame_status(o_frame_status),
        .o_relay_level (o_relay_level)
    );

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import mbrs_pkg::*;

    localparam int FRAME_DEPTH     = 32;
    localparam int SETTLE_CYC      = 40;
    localparam int IDLE_LIMIT      = 2000;
    localparam int BYTES_PER_PHASE = 36;

    typedef struct {
        logic       txv;
        logic [7:0] txb;
        logic       last;
        logic [1:0] st;
        logic       relay;
    } t_tx_beat;

    typedef struct packed {
        logic [3:0]  n;
        logic [47:0] d;
        logic        seal;
        logic [2:0]  btn;
        logic        typed;
        logic [1:0]  st;
        logic        relay;
    } t_dir_row;

    localparam t_dir_row DIR_TBL [6] = '{
        '{4'd1, 48'hFF_00_00_00_00_00, 1'b0, 3'd0, 1'b1, ST_CRC_ERR,       1'b0},
        '{4'd3, 48'h00_00_00_00_00_00, 1'b0, 3'd7, 1'b1, ST_CRC_ERR,       1'b0},
        '{4'd4, 48'h01_02_00_00_00_00, 1'b1, 3'd7, 1'b0, ST_ANSWERED,      1'b0},
        '{4'd4, 48'hFF_02_00_00_00_00, 1'b1, 3'd5, 1'b1, ST_OTHER_STATION, 1'b0},
        '{4'd6, 48'h01_05_00_00_FF_00, 1'b1, 3'd2, 1'b0, ST_ANSWERED,      1'b0},
        '{4'd2, 48'h01_05_00_00_00_00, 1'b1, 3'd1, 1'b1, ST_UNHANDLED,     1'b1}
    };

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte       = 8'h00;
    logic        i_frame_end     = 1'b0;
    logic [2:0]  i_button_levels = 3'd0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic        o_tx_valid;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic [1:0]  o_frame_status;
    logic        o_relay_level;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = CFG_SLAVE_ADDR;
    logic [15:0] i_cfg_data      = 16'h0000;

    logic [7:0]  rx_store [FRAME_DEPTH];
    int unsigned rx_len   = 0;
    bit          rx_drop  = 1'b0;
    bit          relay_q  = 1'b0;
    logic [7:0]  slave_q  = 8'd1;
    logic [15:0] coil_q   = 16'h0000;
    logic [15:0] inputs_q = 16'h0000;

    t_tx_beat    reply_q[$];
    t_tx_beat    tx_due[$];
    logic [7:0]  frame_q[$];
    logic [2:0]  frame_btn;

    bit quiet       = 1'b0;
    int fail_cnt    = 0;
    int bytes_sent  = 0;
    int frames_sent = 0;
    int beats_seen  = 0;
    int cfg_writes  = 0;
    int stall_left  = 0;
    int idle_cyc    = 0;

    modbus_rtu_slave_responder #(
        .FRAME_BYTES(FRAME_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .i_button_levels(i_button_levels),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tx_valid     (o_tx_valid),
        .o_tx_byte      (o_tx_byte),
        .o_tx_last      (o_tx_last),
        .o_frame_status (o_frame_status),
        .o_relay_level  (o_relay_level),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void push_reply(input logic txv, input logic [7:0] txb,
                                       input logic last, input logic [1:0] st);
        t_tx_beat t;
        t.txv   = txv;
        t.txb   = txb;
        t.last  = last;
        t.st    = st;
        t.relay = relay_q;
        reply_q.push_back(t);
    endfunction

    function automatic void take_rx_byte(input logic [7:0] rx, input logic fe,
                                         input logic [2:0] btn);
        int unsigned n;
        logic [15:0] crc;
        logic [15:0] adr;
        logic [7:0]  rsp [6];
        reply_q.delete();
        if (rx_len < FRAME_DEPTH) begin
            rx_store[rx_len] = rx;
            rx_len++;
        end else begin
            rx_drop = 1'b1;
        end
        if (!fe) return;
        n      = rx_len;
        rx_len = 0;
        if (rx_drop || n < MIN_FRAME_BYTES) begin
            rx_drop = 1'b0;
            push_reply(1'b0, 8'h00, 1'b1, ST_CRC_ERR);
            return;
        end
        crc = CRC_INIT;
        for (int i = 0; i < n - 2; i++) crc = crc_feed(crc, rx_store[i]);
        if (crc != {rx_store[n-1], rx_store[n-2]}) begin
            push_reply(1'b0, 8'h00, 1'b1, ST_CRC_ERR);
            return;
        end
        if (rx_store[0] != slave_q) begin
            push_reply(1'b0, 8'h00, 1'b1, ST_OTHER_STATION);
            return;
        end
        adr = {rx_store[2], rx_store[3]};
        if (rx_store[1] == FC_READ_INPUTS && adr == inputs_q) begin
            rsp[0] = rx_store[0];
            rsp[1] = FC_READ_INPUTS;
            rsp[2] = READ_BYTE_COUNT;
            rsp[3] = {4'h0, relay_q, btn};
            crc = CRC_INIT;
            for (int i = 0; i < 4; i++) crc = crc_feed(crc, rsp[i]);
            rsp[4] = crc[7:0];
            rsp[5] = crc[15:8];
            for (int i = 0; i < 6; i++) push_reply(1'b1, rsp[i], i == 5, ST_ANSWERED);
        end else if (rx_store[1] == FC_WRITE_COIL && adr == coil_q &&
                     n >= MIN_ECHO_BYTES && n <= MAX_RESULTS) begin
            relay_q = (rx_store[4] == COIL_ON);
            for (int i = 0; i < n; i++) push_reply(1'b1, rx_store[i], i == n - 1, ST_ANSWERED);
        end else begin
            push_reply(1'b0, 8'h00, 1'b1, ST_UNHANDLED);
        end
    endfunction

    function automatic int pick_gap(input int longest);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, longest);
    endfunction

    function automatic void seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[k]) c = crc_feed(c, frame_q[k]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endfunction

    function automatic void build_random_frame();
        int r, b, body, len, k;
        logic [7:0]  sa, data;
        logic [15:0] adr;
        frame_q.delete();
        frame_btn = 3'($urandom);
        r  = $urandom_range(0, 99);
        sa = ($urandom_range(0, 9) == 0) ? 8'($urandom) : slave_q;
        if (r < 35) begin
            adr = ($urandom_range(0, 6) == 0) ? 16'($urandom) : inputs_q;
            frame_q.push_back(sa);
            frame_q.push_back(FC_READ_INPUTS);
            frame_q.push_back(adr[15:8]);
            frame_q.push_back(adr[7:0]);
            repeat ($urandom_range(0, 2)) frame_q.push_back(8'($urandom));
            seal_frame();
        end else if (r < 70) begin
            adr  = ($urandom_range(0, 6) == 0) ? 16'($urandom) : coil_q;
            b    = $urandom_range(0, 4);
            data = (b < 2) ? COIL_ON : (b < 4) ? 8'h00 : 8'($urandom);
            frame_q.push_back(sa);
            frame_q.push_back(FC_WRITE_COIL);
            frame_q.push_back(adr[15:8]);
            frame_q.push_back(adr[7:0]);
            frame_q.push_back(data);
            frame_q.push_back(8'h00);
            b    = $urandom_range(0, 19);
            body = (b < 12) ? 6 : (b < 16) ? $urandom_range(1, 30) : MAX_RESULTS - 2;
            while (frame_q.size() > body) void'(frame_q.pop_back());
            while (frame_q.size() < body) frame_q.push_back(8'($urandom));
            seal_frame();
        end else begin
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(FRAME_DEPTH + 1, FRAME_DEPTH + 8)
                                              : $urandom_range(1, 20);
            repeat (len) frame_q.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1) frame_q[0] = sa;
            if ($urandom_range(0, 1) == 1) seal_frame();
        end
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, frame_q.size() - 1);
            frame_q[k] = frame_q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
    endfunction

    task automatic send_frame(input logic typed, input t_tx_beat fixed);
        int last;
        int gap;
        logic [2:0] btn;
        last = frame_q.size() - 1;
        for (int k = 0; k <= last; k++) begin
            btn = (k == last) ? frame_btn : 3'($urandom);
            i_valid         <= 1'b1;
            i_rx_byte       <= frame_q[k];
            i_frame_end     <= (k == last);
            i_button_levels <= btn;
            do @(posedge i_clk); while (o_stall);
            take_rx_byte(frame_q[k], k == last, btn);
            bytes_sent++;
            if (typed && k == last) begin
                tx_due.push_back(fixed);
            end else begin
                foreach (reply_q[j]) tx_due.push_back(reply_q[j]);
            end
            gap = pick_gap(30);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        frames_sent++;
    endtask

    // drain every pending response, then hold off for the block to go idle
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tx_due.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] sa, input logic [15:0] ca,
                              input logic [15:0] ia);
        logic [1:0]  idx [3];
        logic [15:0] val [3];
        idx = '{CFG_SLAVE_ADDR, CFG_COIL_ADDR, CFG_INPUTS_ADDR};
        val = '{{8'($urandom), sa}, ca, ia};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            cfg_writes++;
        end
        i_cfg_valid <= 1'b0;
        slave_q  = sa;
        coil_q   = ca;
        inputs_q = ia;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_tx_beat want;
        int g;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (tx_due.size() == 0) begin
                $error("tx transfer with nothing pending: tx_byte %0h", o_tx_byte);
                fail_cnt++;
            end else begin
                want = tx_due.pop_front();
                check_field("tx_valid", want.txv, o_tx_valid);
                check_field("tx_byte", want.txb, o_tx_byte);
                check_field("tx_last", want.last, o_tx_last);
                check_field("frame_status", want.st, o_frame_status);
                check_field("relay_level", want.relay, o_relay_level);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            g = pick_gap(40);
            i_stall    <= (g > 0);
            stall_left = (g > 0) ? g - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_tx_beat    fixed;
        logic [15:0] ca;
        int          start;
        bit          paused;
        paused = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TBL[r]) begin
            frame_q.delete();
            for (int k = 0; k < DIR_TBL[r].n; k++) frame_q.push_back(DIR_TBL[r].d[47 - 8*k -: 8]);
            if (DIR_TBL[r].seal) seal_frame();
            frame_btn = DIR_TBL[r].btn;
            fixed     = '{1'b0, 8'h00, 1'b1, DIR_TBL[r].st, DIR_TBL[r].relay};
            send_frame(DIR_TBL[r].typed, fixed);
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle(SETTLE_CYC);
            ca = 16'($urandom);
            case (ph)
                0: set_config(8'h00, 16'hFFFF, 16'hFFFF);
                1: set_config(8'hFF, 16'h0000, 16'($urandom));
                2: set_config(8'($urandom), ca, 16'($urandom));
                default: set_config(8'($urandom), ca, ca);
            endcase
            quiet = (ph == 1);
            start = bytes_sent;
            while (bytes_sent - start < BYTES_PER_PHASE) begin
                if (ph == 2 && !paused && bytes_sent - start > BYTES_PER_PHASE / 2) begin
                    settle(0);
                    paused = 1'b1;
                end
                build_random_frame();
                send_frame(1'b0, fixed);
            end
        end
        settle(SETTLE_CYC);

        $display("covered %0d rx bytes in %0d frames over 5 address settings, %0d config writes",
                 bytes_sent, frames_sent, cfg_writes);
        $display("compared %0d tx transfers; reads, coil writes, short, overflowed and bad frames",
                 beats_seen);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
